>>> rtl/atod_pkg.sv
// Shared constants, register codes and helpers for the onset detector.
package atod_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam int AMP_W   = 16;
    localparam int TIME_W  = 32;
    localparam int THR_W   = 32;
    localparam int LAST_W  = 34;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    // divider geometry: 16-bit divisor, four quotient bits per cycle
    localparam int DIVR_W        = 16;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIVD_MIN_W    = 40;

    localparam int AVG_SHIFT   = 14;
    localparam int EXC_SHIFT   = 8;
    localparam int FLOOR_SHIFT = 35;

    localparam logic [DIVR_W-1:0] DIV_MIN = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LEVEL       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCESS_DIVIDER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_DIVIDER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_DIVIDER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_DELAY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_WAIT        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_WAIT     = 3'd7;

    localparam logic [6:0]        RST_WINDOW_LENGTH    = 7'd8;
    localparam logic [15:0]       RST_FILL_LEVEL       = 16'd0;
    localparam logic [15:0]       RST_EXCESS_DIVIDER   = 16'd512;
    localparam logic [15:0]       RST_UPDATE_DIVIDER   = 16'd1024;
    localparam logic [15:0]       RST_DECREASE_DIVIDER = 16'd4096;

    // dividers below 1.0 (Q8.8) act as 1.0
    function automatic logic [DIVR_W-1:0] div_eff(input logic [DIVR_W-1:0] v);
        return (v < DIV_MIN) ? DIV_MIN : v;
    endfunction

endpackage

>>> rtl/atod_in_if.sv
// Input sample channel: amplitude, timestamp and run marker.
interface atod_in_if;
    logic                        valid;
    logic                        ready;
    logic [atod_pkg::AMP_W-1:0]  sample_amplitude;
    logic [atod_pkg::TIME_W-1:0] sample_time;
    logic                        run_last;

    modport source(output valid, sample_amplitude, sample_time, run_last, input ready);
    modport sink(input valid, sample_amplitude, sample_time, run_last, output ready);
endinterface

>>> rtl/atod_out_if.sv
// Result channel: onset flag, timestamp and run summary.
interface atod_out_if;
    logic                        valid;
    logic                        ready;
    logic                        onset_flag;
    logic [atod_pkg::TIME_W-1:0] onset_time;
    logic                        run_end;
    logic                        any_onset;

    modport source(output valid, onset_flag, onset_time, run_end, any_onset, input ready);
    modport sink(input valid, onset_flag, onset_time, run_end, any_onset, output ready);
endinterface

>>> rtl/adaptive_threshold_onset_detector.sv
// Top level of the adaptive-threshold onset detector.
// Samples enter on i_sample (valid/ready); a transaction carries amplitude,
// timestamp and run_last. Results leave on o_result: one result for a sample
// that fires an onset or closes a run, none otherwise.
// Registers are written through i_cfg_we/i_cfg_index/i_cfg_data; the user
// must write them only while idle, as the block does not enforce it.
// The window lives in a one-read, one-write RAM used as a circular buffer;
// a fill count stands in for the prefill at run start, so no clearing pass.
// One sample at a time: each takes two to four divisions on the shared
// divider (four quotient bits per cycle): average, excess or floor, tracking,
// decay. Ready returns with the result, so a new sample is taken only after
// the previous one is through.
// A finished result waits in the output register; the next sample is taken
// meanwhile and only its final step stalls if that register is still full.
// Reset clears the threshold, last onset time, run state and the registers
// to their defaults; the window length and fill level latch at run start.
module adaptive_threshold_onset_detector #(
    parameter int WINDOW_MAX = atod_pkg::WINDOW_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    atod_in_if.sink                        i_sample,
    atod_out_if.source                     o_result,
    input  logic                           i_cfg_we,
    input  logic [atod_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [atod_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int AMP_W  = atod_pkg::AMP_W;
    localparam int TIME_W = atod_pkg::TIME_W;
    localparam int THR_W  = atod_pkg::THR_W;
    localparam int LAST_W = atod_pkg::LAST_W;
    localparam int DIVR_W = atod_pkg::DIVR_W;
    localparam int PTR_W  = $clog2(WINDOW_MAX);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = AMP_W + LEN_W;
    localparam int D_W    = LAST_W + 1;
    localparam int DIVD_RAW = (SUM_W + atod_pkg::AVG_SHIFT > atod_pkg::DIVD_MIN_W) ?
                              SUM_W + atod_pkg::AVG_SHIFT : atod_pkg::DIVD_MIN_W;
    localparam int DIVD_W = ((DIVD_RAW + atod_pkg::DIV_STEP_BITS - 1) /
                             atod_pkg::DIV_STEP_BITS) * atod_pkg::DIV_STEP_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_SUM,
        S_AVG, S_AVG_W, S_EXC, S_EXC_W,
        S_TRK, S_TRK_W, S_DEC, S_DEC_W, S_FIN
    } t_state;

    // configuration
    logic [6:0]        r_cfg_len;
    logic [15:0]       r_cfg_fill;
    logic [15:0]       r_cfg_exc;
    logic [15:0]       r_cfg_upd;
    logic [15:0]       r_cfg_dec;
    logic [31:0]       r_cfg_delay;
    logic [31:0]       r_cfg_step;
    logic [31:0]       r_cfg_tmo;

    t_state              r_state;
    logic [AMP_W-1:0]    r_amp;
    logic [TIME_W-1:0]   r_time;
    logic                r_last;
    logic                r_run_open;
    logic                r_any;
    logic [LEN_W-1:0]    r_len;
    logic [AMP_W-1:0]    r_fill_run;
    logic [PTR_W-1:0]    r_ptr;
    logic [LEN_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    r_sum;
    logic signed [D_W-1:0] r_d;
    logic                r_decay;
    logic                r_tmo;
    logic                r_step_ok;
    logic [THR_W-1:0]    r_avg;
    logic [THR_W-1:0]    r_cand;
    logic [THR_W-1:0]    r_thr;
    logic [LAST_W-1:0]   r_last_onset;

    logic                r_out_valid;
    logic                r_out_flag;
    logic [TIME_W-1:0]   r_out_time;
    logic                r_out_end;
    logic                r_out_any;

    logic [31:0]         cfg_len32;
    logic [LEN_W-1:0]    n_len;
    logic [SUM_W-1:0]    n_sum_start;
    logic [AMP_W-1:0]    oldest;
    logic [SUM_W-1:0]    n_sum;
    logic [LEN_W-1:0]    ptr_inc;
    logic [PTR_W-1:0]    n_ptr;
    logic signed [D_W-1:0] n_d;
    logic                floor_mode;
    logic signed [THR_W:0] trk_diff;
    logic                trk_neg;
    logic [THR_W-1:0]    trk_mag;
    logic [THR_W-1:0]    q32;
    logic                amp_over;
    logic                onset;
    logic                emit;
    logic                can_load;
    logic                in_fire;

    logic                div_start;
    logic [DIVD_W-1:0]   div_dividend;
    logic [DIVR_W-1:0]   div_divisor;
    logic                div_done;
    logic [DIVD_W-1:0]   div_quo;

    logic [AMP_W-1:0]    ram_rdata;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= atod_pkg::RST_WINDOW_LENGTH;
            r_cfg_fill  <= atod_pkg::RST_FILL_LEVEL;
            r_cfg_exc   <= atod_pkg::RST_EXCESS_DIVIDER;
            r_cfg_upd   <= atod_pkg::RST_UPDATE_DIVIDER;
            r_cfg_dec   <= atod_pkg::RST_DECREASE_DIVIDER;
            r_cfg_delay <= '0;
            r_cfg_step  <= '0;
            r_cfg_tmo   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                atod_pkg::CFG_WINDOW_LENGTH:    r_cfg_len   <= i_cfg_data[6:0];
                atod_pkg::CFG_FILL_LEVEL:       r_cfg_fill  <= i_cfg_data[15:0];
                atod_pkg::CFG_EXCESS_DIVIDER:   r_cfg_exc   <= i_cfg_data[15:0];
                atod_pkg::CFG_UPDATE_DIVIDER:   r_cfg_upd   <= i_cfg_data[15:0];
                atod_pkg::CFG_DECREASE_DIVIDER: r_cfg_dec   <= i_cfg_data[15:0];
                atod_pkg::CFG_DECREASE_DELAY:   r_cfg_delay <= i_cfg_data;
                atod_pkg::CFG_STEP_WAIT:        r_cfg_step  <= i_cfg_data;
                atod_pkg::CFG_TIMEOUT_WAIT:     r_cfg_tmo   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath
    assign cfg_len32 = 32'(r_cfg_len);
    assign n_len = (cfg_len32 < 32'd2) ? LEN_W'(2) :
                   (cfg_len32 > 32'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX) : LEN_W'(cfg_len32);
    assign n_sum_start = SUM_W'(SUM_W'(r_cfg_fill) * SUM_W'(n_len));

    // entries not yet written this run still hold the prefill level
    assign oldest  = (r_cnt < r_len) ? r_fill_run : ram_rdata;
    assign n_sum   = r_sum - SUM_W'(oldest) + SUM_W'(r_amp);
    assign ptr_inc = LEN_W'(r_ptr) + LEN_W'(1);
    assign n_ptr   = (ptr_inc == r_len) ? '0 : PTR_W'(ptr_inc);

    assign n_d = $signed(D_W'(r_time)) - $signed(D_W'(r_last_onset));

    assign floor_mode = (r_last_onset == '0) || (r_avg == '0);
    assign q32        = div_quo[THR_W-1:0];

    assign trk_diff = $signed({1'b0, r_cand}) - $signed({1'b0, r_thr});
    assign trk_neg  = trk_diff[THR_W];
    assign trk_mag  = trk_neg ? THR_W'(-trk_diff) : THR_W'(trk_diff);

    assign amp_over = (THR_W'(r_amp) << atod_pkg::AVG_SHIFT) > r_thr;
    assign onset    = r_tmo || (r_step_ok && amp_over);
    assign emit     = onset || r_last;
    assign can_load = !r_out_valid || o_result.ready;
    assign in_fire  = i_sample.valid && i_sample.ready;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (r_state)
            S_AVG: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(r_sum) << atod_pkg::AVG_SHIFT;
                div_divisor  = DIVR_W'(r_len - LEN_W'(1));
            end
            S_EXC: begin
                div_start    = 1'b1;
                div_dividend = floor_mode ? (DIVD_W'(1) << atod_pkg::FLOOR_SHIFT) :
                                            (DIVD_W'(r_avg) << atod_pkg::EXC_SHIFT);
                div_divisor  = atod_pkg::div_eff(r_cfg_exc);
            end
            S_TRK: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(trk_mag) << atod_pkg::EXC_SHIFT;
                div_divisor  = atod_pkg::div_eff(r_cfg_upd);
            end
            S_DEC: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(r_thr) << atod_pkg::EXC_SHIFT;
                div_divisor  = atod_pkg::div_eff(r_cfg_dec);
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_open   <= 1'b0;
            r_any        <= 1'b0;
            r_thr        <= '0;
            r_last_onset <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_amp  <= i_sample.sample_amplitude;
                        r_time <= i_sample.sample_time;
                        r_last <= i_sample.run_last;
                        if (!r_run_open) begin
                            r_len      <= n_len;
                            r_fill_run <= r_cfg_fill;
                            r_sum      <= n_sum_start;
                            r_ptr      <= '0;
                            r_cnt      <= '0;
                            r_any      <= 1'b0;
                            r_run_open <= 1'b1;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_d     <= n_d;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum     <= n_sum;
                    r_ptr     <= n_ptr;
                    if (r_cnt < r_len) begin
                        r_cnt <= r_cnt + LEN_W'(1);
                    end
                    r_decay   <= r_d > $signed(D_W'(r_cfg_delay));
                    r_tmo     <= (r_cfg_tmo != '0) && (r_d > $signed(D_W'(r_cfg_tmo)));
                    r_step_ok <= (r_cfg_step == '0) || (r_d >= $signed(D_W'(r_cfg_step)));
                    r_state   <= S_AVG;
                end
                S_AVG:   r_state <= S_AVG_W;
                S_AVG_W: begin
                    if (div_done) begin
                        r_avg   <= q32;
                        r_state <= S_EXC;
                    end
                end
                S_EXC:   r_state <= S_EXC_W;
                S_EXC_W: begin
                    if (div_done) begin
                        if (floor_mode) begin
                            r_thr   <= q32;
                            r_state <= r_decay ? S_DEC : S_FIN;
                        end else begin
                            r_cand  <= r_avg + q32;
                            r_state <= S_TRK;
                        end
                    end
                end
                S_TRK:   r_state <= S_TRK_W;
                S_TRK_W: begin
                    if (div_done) begin
                        r_thr   <= trk_neg ? (r_thr - q32) : (r_thr + q32);
                        r_state <= r_decay ? S_DEC : S_FIN;
                    end
                end
                S_DEC:   r_state <= S_DEC_W;
                S_DEC_W: begin
                    if (div_done) begin
                        r_thr   <= r_thr - q32;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold here while the previous result still waits and this sample has a result to emit
                    if (!emit || can_load) begin
                        if (r_tmo) begin
                            r_last_onset <= LAST_W'(r_time) + LAST_W'(r_cfg_step);
                        end else if (onset) begin
                            r_last_onset <= LAST_W'(r_time);
                        end
                        if (emit) begin
                            r_out_valid <= 1'b1;
                            r_out_flag  <= onset;
                            r_out_time  <= r_time;
                            r_out_end   <= r_last;
                            r_out_any   <= r_last && (r_any || onset);
                        end
                        if (r_last) begin
                            r_run_open <= 1'b0;
                            r_any      <= 1'b0;
                        end else if (onset) begin
                            r_any <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_sample.ready      = (r_state == S_IDLE);
    assign o_result.valid      = r_out_valid;
    assign o_result.onset_flag = r_out_flag;
    assign o_result.onset_time = r_out_time;
    assign o_result.run_end    = r_out_end;
    assign o_result.any_onset  = r_out_any;

    // ---------------------------------------------------------------- units
    atod_ram #(
        .WIDTH(AMP_W),
        .DEPTH(WINDOW_MAX)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (r_state == S_SUM),
        .i_waddr(r_ptr),
        .i_wdata(r_amp),
        .i_re   (r_state == S_READ),
        .i_raddr(r_ptr),
        .o_rdata(ram_rdata)
    );

    atod_div #(
        .DIVD_W(DIVD_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // ---------------------------------------------------------------- checks
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_AVG_W || r_state == S_EXC_W ||
                      r_state == S_TRK_W || r_state == S_DEC_W))
        else $error("divider finished outside a wait state");

    a_window_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_open && r_state != S_IDLE && r_state != S_READ) |->
            (LEN_W'(r_ptr) < r_len) && (r_cnt <= r_len))
        else $error("window pointer or fill count out of range");

    a_run_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && can_load && r_last) |=> (!r_run_open && !r_any))
        else $error("run not closed after its last sample");

    a_accept_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_READ && r_run_open))
        else $error("accepted sample did not start processing in an open run");

endmodule

>>> rtl/atod_ram.sv
// Generic single-write, single-read RAM with registered read data.
module atod_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/atod_div.sv
// Iterative unsigned restoring divider, several quotient bits per cycle.
module atod_div #(
    parameter int DIVD_W = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DIVD_W-1:0]           i_dividend,
    input  logic [atod_pkg::DIVR_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [DIVD_W-1:0]           o_quotient
);
    localparam int DIVR_W = atod_pkg::DIVR_W;
    localparam int STEP_BITS = atod_pkg::DIV_STEP_BITS;
    localparam int STEPS = DIVD_W / STEP_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic [DIVR_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVR_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVR_W-1:0] n_rem;
    logic [DIVD_W-1:0] n_quo;

    // dividend shifts out the top of r_quo while quotient bits fill the bottom
    always_comb begin
        logic [DIVR_W:0] rem_w;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < STEP_BITS; k++) begin
            rem_w = {n_rem, n_quo[DIVD_W-1]};
            n_quo = {n_quo[DIVD_W-2:0], 1'b0};
            if (rem_w >= {1'b0, r_dvs}) begin
                rem_w    = rem_w - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = rem_w[DIVR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
